@@ rtl/rau_pkg.sv @@
package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int NUM_OUT_W         = 33;
    localparam int DEN_OUT_W         = 32;
    localparam int RAW_MAX_W         = 64;

    typedef logic [1:0] cmd_t;

    localparam cmd_t CMD_ADD = 2'd0;
    localparam cmd_t CMD_SUB = 2'd1;
    localparam cmd_t CMD_MUL = 2'd2;
    localparam cmd_t CMD_DIV = 2'd3;

    typedef struct packed {
        logic valid;
        logic n_neg;
        logic d_neg;
        logic eq;
    } rau_ctl_t;

    function automatic int raw_width(input int w);
        return (2 * w + 1 > RAW_MAX_W) ? RAW_MAX_W : 2 * w + 1;
    endfunction

endpackage

@@ rtl/rau_in_if.sv @@
interface rau_in_if
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) ();
    logic                            valid;
    logic                            ready;
    cmd_t                            command;
    logic signed [OPERAND_WIDTH-1:0] left_num;
    logic signed [OPERAND_WIDTH-1:0] left_den;
    logic signed [OPERAND_WIDTH-1:0] right_num;
    logic signed [OPERAND_WIDTH-1:0] right_den;

    modport source (
        output valid, command, left_num, left_den, right_num, right_den,
        input  ready
    );

    modport sink (
        input  valid, command, left_num, left_den, right_num, right_den,
        output ready
    );
endinterface

@@ rtl/rau_out_if.sv @@
interface rau_out_if
    import rau_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic signed [NUM_OUT_W-1:0] result_num;
    logic signed [DEN_OUT_W-1:0] result_den;
    logic                        undefined;
    logic                        operands_equal;

    modport source (
        output valid, result_num, result_den, undefined, operands_equal,
        input  ready
    );

    modport sink (
        input  valid, result_num, result_den, undefined, operands_equal,
        output ready
    );
endinterface

@@ rtl/rational_arithmetic_unit.sv @@
// Fully pipelined rational add, subtract, multiply and divide with GCD reduction. One
// transaction can enter every cycle unless the result side stalls. RW is
// 2*OPERAND_WIDTH+1 capped at 64. The operand front end is followed by the binary
// GCD (2*RW one-step stages) and then by the two exact divisions by the GCD
// (RW restoring stages). A stall on the result side holds the whole pipeline; nothing
// is dropped. Denominator signs are left as the arithmetic produces them.
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    rau_in_if.sink    operands,
    rau_out_if.source result
);
    localparam int RW = raw_width(OPERAND_WIDTH);
    localparam int KW = $clog2(RW + 1);
    localparam int GS = 2 * RW;
    localparam int DS = RW;

    logic en;

    rau_ctl_t      g_ctl [GS+1];
    logic [RW-1:0] g_a   [GS+1];
    logic [RW-1:0] g_b   [GS+1];
    logic [KW-1:0] g_k   [GS+1];
    logic [RW-1:0] g_n   [GS+1];
    logic [RW-1:0] g_d   [GS+1];

    rau_ctl_t      fin_ctl_reg;
    logic [RW-1:0] fin_g_reg;
    logic [RW-1:0] fin_n_reg;
    logic [RW-1:0] fin_d_reg;
    logic [RW-1:0] fin_g_next;

    rau_ctl_t      v_ctl [DS+1];
    logic [RW-1:0] v_g   [DS+1];
    logic [RW-1:0] v_nq  [DS+1];
    logic [RW-1:0] v_nr  [DS+1];
    logic [RW-1:0] v_dq  [DS+1];
    logic [RW-1:0] v_dr  [DS+1];

    logic signed [RW-1:0]        num_s;
    logic signed [RW-1:0]        den_s;
    logic signed [RAW_MAX_W-1:0] num_ext;
    logic signed [RAW_MAX_W-1:0] den_ext;
    logic                        undef_next;

    logic                        out_valid_reg;
    logic signed [NUM_OUT_W-1:0] num_reg;
    logic signed [DEN_OUT_W-1:0] den_reg;
    logic                        undef_reg;
    logic                        eq_reg;

    assign en             = !out_valid_reg || result.ready;
    assign operands.ready = en;

    rau_front #(
        .OPERAND_WIDTH (OPERAND_WIDTH),
        .RW            (RW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (operands.valid),
        .command   (operands.command),
        .left_num  (operands.left_num),
        .left_den  (operands.left_den),
        .right_num (operands.right_num),
        .right_den (operands.right_den),
        .ctl       (g_ctl[0]),
        .n_mag     (g_n[0]),
        .d_mag     (g_d[0])
    );

    assign g_a[0] = g_n[0];
    assign g_b[0] = g_d[0];
    assign g_k[0] = '0;

    for (genvar i = 0; i < GS; i++)
    begin : gen_gcd
        rau_gcd_step #(
            .RW (RW),
            .KW (KW)
        ) u_gcd_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (g_ctl[i]),
            .a_in    (g_a[i]),
            .b_in    (g_b[i]),
            .k_in    (g_k[i]),
            .n_in    (g_n[i]),
            .d_in    (g_d[i]),
            .ctl_out (g_ctl[i+1]),
            .a_out   (g_a[i+1]),
            .b_out   (g_b[i+1]),
            .k_out   (g_k[i+1]),
            .n_out   (g_n[i+1]),
            .d_out   (g_d[i+1])
        );
    end

    assign fin_g_next = (g_a[GS] | g_b[GS]) << g_k[GS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_ctl_reg <= '0;
        end
        else if (en)
        begin
            fin_ctl_reg <= g_ctl[GS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_g_reg <= fin_g_next;
            fin_n_reg <= g_n[GS];
            fin_d_reg <= g_d[GS];
        end
    end

    assign v_ctl[0] = fin_ctl_reg;
    assign v_g[0]   = fin_g_reg;
    assign v_nq[0]  = fin_n_reg;
    assign v_nr[0]  = '0;
    assign v_dq[0]  = fin_d_reg;
    assign v_dr[0]  = '0;

    for (genvar j = 0; j < DS; j++)
    begin : gen_div
        rau_div_step #(
            .RW (RW)
        ) u_div_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (v_ctl[j]),
            .g_in    (v_g[j]),
            .nq_in   (v_nq[j]),
            .nr_in   (v_nr[j]),
            .dq_in   (v_dq[j]),
            .dr_in   (v_dr[j]),
            .ctl_out (v_ctl[j+1]),
            .g_out   (v_g[j+1]),
            .nq_out  (v_nq[j+1]),
            .nr_out  (v_nr[j+1]),
            .dq_out  (v_dq[j+1]),
            .dr_out  (v_dr[j+1])
        );
    end

    always_comb
    begin
        undef_next = (v_g[DS] == '0);
        num_s      = v_ctl[DS].n_neg ? (~v_nq[DS] + 1'b1) : v_nq[DS];
        den_s      = v_ctl[DS].d_neg ? (~v_dq[DS] + 1'b1) : v_dq[DS];
        num_ext    = RAW_MAX_W'(num_s);
        den_ext    = RAW_MAX_W'(den_s);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v_ctl[DS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg   <= undef_next ? '0 : num_ext[NUM_OUT_W-1:0];
            den_reg   <= undef_next ? '0 : den_ext[DEN_OUT_W-1:0];
            undef_reg <= undef_next;
            eq_reg    <= v_ctl[DS].eq;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.result_num     = num_reg;
    assign result.result_den     = den_reg;
    assign result.undefined      = undef_reg;
    assign result.operands_equal = eq_reg;

    a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.undefined |-> result.result_num == '0 && result.result_den == '0)
        else $error("undefined result not forced to 0/0");

    a_defined_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (2 * OPERAND_WIDTH <= DEN_OUT_W) && result.valid && !result.undefined
        |-> result.result_num != '0 || result.result_den != '0)
        else $error("defined result reduced to 0/0");

    a_zero_den_unit_num: assert property (@(posedge clk) disable iff (!rst_n)
        (2 * OPERAND_WIDTH <= DEN_OUT_W) && result.valid && !result.undefined
        && result.result_den == '0
        |-> result.result_num == NUM_OUT_W'(1) || result.result_num == '1)
        else $error("zero denominator without unit numerator");
endmodule

@@ rtl/rau_front.sv @@
module rau_front
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF,
    parameter int RW            = raw_width(OPERAND_WIDTH)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  cmd_t                            command,
    input  logic signed [OPERAND_WIDTH-1:0] left_num,
    input  logic signed [OPERAND_WIDTH-1:0] left_den,
    input  logic signed [OPERAND_WIDTH-1:0] right_num,
    input  logic signed [OPERAND_WIDTH-1:0] right_den,
    output rau_ctl_t                        ctl,
    output logic [RW-1:0]                   n_mag,
    output logic [RW-1:0]                   d_mag
);
    localparam int PW = 2 * OPERAND_WIDTH;

    logic                 a_valid_reg;
    logic                 a_eq_reg;
    cmd_t                 a_cmd_reg;
    logic signed [PW-1:0] p_lr_reg;
    logic signed [PW-1:0] p_dr_reg;
    logic signed [PW-1:0] p_ln_reg;
    logic signed [PW-1:0] p_dd_reg;
    logic signed [PW-1:0] p_lr_next;
    logic signed [PW-1:0] p_dr_next;
    logic signed [PW-1:0] p_ln_next;
    logic signed [PW-1:0] p_dd_next;

    logic signed [RW-1:0] lr_x;
    logic signed [RW-1:0] dr_x;
    logic signed [RW-1:0] ln_x;
    logic signed [RW-1:0] dd_x;
    logic signed [RW-1:0] n_raw;
    logic signed [RW-1:0] d_raw;

    rau_ctl_t      ctl_reg;
    rau_ctl_t      ctl_next;
    logic [RW-1:0] n_mag_reg;
    logic [RW-1:0] d_mag_reg;
    logic [RW-1:0] n_mag_next;
    logic [RW-1:0] d_mag_next;

    always_comb
    begin
        p_lr_next = left_num * right_den;
        p_dr_next = left_den * right_num;
        p_ln_next = left_num * right_num;
        p_dd_next = left_den * right_den;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_eq_reg  <= (left_num == right_num) && (left_den == right_den);
            a_cmd_reg <= command;
            p_lr_reg  <= p_lr_next;
            p_dr_reg  <= p_dr_next;
            p_ln_reg  <= p_ln_next;
            p_dd_reg  <= p_dd_next;
        end
    end

    always_comb
    begin
        lr_x = RW'(p_lr_reg);
        dr_x = RW'(p_dr_reg);
        ln_x = RW'(p_ln_reg);
        dd_x = RW'(p_dd_reg);
        unique case (a_cmd_reg)
            CMD_ADD: n_raw = lr_x + dr_x;
            CMD_SUB: n_raw = lr_x - dr_x;
            CMD_MUL: n_raw = ln_x;
            CMD_DIV: n_raw = lr_x;
            default: n_raw = lr_x;
        endcase
        d_raw = (a_cmd_reg == CMD_DIV) ? dr_x : dd_x;
        n_mag_next = n_raw[RW-1] ? (~n_raw + 1'b1) : n_raw;
        d_mag_next = d_raw[RW-1] ? (~d_raw + 1'b1) : d_raw;
        ctl_next.valid = a_valid_reg;
        ctl_next.n_neg = n_raw[RW-1];
        ctl_next.d_neg = d_raw[RW-1];
        ctl_next.eq    = a_eq_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_mag_reg <= n_mag_next;
            d_mag_reg <= d_mag_next;
        end
    end

    assign ctl   = ctl_reg;
    assign n_mag = n_mag_reg;
    assign d_mag = d_mag_reg;
endmodule

@@ rtl/rau_gcd_step.sv @@
module rau_gcd_step
    import rau_pkg::*;
#(
    parameter int RW = raw_width(OPERAND_WIDTH_DEF),
    parameter int KW = $clog2(RW + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  rau_ctl_t      ctl_in,
    input  logic [RW-1:0] a_in,
    input  logic [RW-1:0] b_in,
    input  logic [KW-1:0] k_in,
    input  logic [RW-1:0] n_in,
    input  logic [RW-1:0] d_in,
    output rau_ctl_t      ctl_out,
    output logic [RW-1:0] a_out,
    output logic [RW-1:0] b_out,
    output logic [KW-1:0] k_out,
    output logic [RW-1:0] n_out,
    output logic [RW-1:0] d_out
);
    rau_ctl_t      ctl_reg;
    logic [RW-1:0] a_reg;
    logic [RW-1:0] b_reg;
    logic [KW-1:0] k_reg;
    logic [RW-1:0] n_reg;
    logic [RW-1:0] d_reg;
    logic [RW-1:0] a_next;
    logic [RW-1:0] b_next;
    logic [KW-1:0] k_next;
    logic [RW-1:0] diff_ab;
    logic [RW-1:0] diff_ba;

    always_comb
    begin
        a_next  = a_in;
        b_next  = b_in;
        k_next  = k_in;
        diff_ab = a_in - b_in;
        diff_ba = b_in - a_in;
        priority if (a_in == '0 || b_in == '0)
        begin
            a_next = a_in;
        end
        else if (!a_in[0] && !b_in[0])
        begin
            a_next = a_in >> 1;
            b_next = b_in >> 1;
            k_next = k_in + 1'b1;
        end
        else if (!a_in[0])
        begin
            a_next = a_in >> 1;
        end
        else if (!b_in[0])
        begin
            b_next = b_in >> 1;
        end
        else if (a_in >= b_in)
        begin
            a_next = diff_ab >> 1;
        end
        else
        begin
            b_next = diff_ba >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            k_reg <= k_next;
            n_reg <= n_in;
            d_reg <= d_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign a_out   = a_reg;
    assign b_out   = b_reg;
    assign k_out   = k_reg;
    assign n_out   = n_reg;
    assign d_out   = d_reg;
endmodule

@@ rtl/rau_div_step.sv @@
module rau_div_step
    import rau_pkg::*;
#(
    parameter int RW = raw_width(OPERAND_WIDTH_DEF)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  rau_ctl_t      ctl_in,
    input  logic [RW-1:0] g_in,
    input  logic [RW-1:0] nq_in,
    input  logic [RW-1:0] nr_in,
    input  logic [RW-1:0] dq_in,
    input  logic [RW-1:0] dr_in,
    output rau_ctl_t      ctl_out,
    output logic [RW-1:0] g_out,
    output logic [RW-1:0] nq_out,
    output logic [RW-1:0] nr_out,
    output logic [RW-1:0] dq_out,
    output logic [RW-1:0] dr_out
);
    rau_ctl_t      ctl_reg;
    logic [RW-1:0] g_reg;
    logic [RW-1:0] nq_reg;
    logic [RW-1:0] nr_reg;
    logic [RW-1:0] dq_reg;
    logic [RW-1:0] dr_reg;
    logic [RW:0]   tn;
    logic [RW:0]   td;
    logic [RW:0]   gx;
    logic          ge_n;
    logic          ge_d;
    logic [RW-1:0] nq_next;
    logic [RW-1:0] nr_next;
    logic [RW-1:0] dq_next;
    logic [RW-1:0] dr_next;

    always_comb
    begin
        gx      = {1'b0, g_in};
        tn      = {nr_in, nq_in[RW-1]};
        td      = {dr_in, dq_in[RW-1]};
        ge_n    = (tn >= gx);
        ge_d    = (td >= gx);
        nr_next = ge_n ? RW'(tn - gx) : tn[RW-1:0];
        dr_next = ge_d ? RW'(td - gx) : td[RW-1:0];
        nq_next = {nq_in[RW-2:0], ge_n};
        dq_next = {dq_in[RW-2:0], ge_d};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_reg  <= g_in;
            nq_reg <= nq_next;
            nr_reg <= nr_next;
            dq_reg <= dq_next;
            dr_reg <= dr_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign g_out   = g_reg;
    assign nq_out  = nq_reg;
    assign nr_out  = nr_reg;
    assign dq_out  = dq_reg;
    assign dr_out  = dr_reg;
endmodule

@@ dv/tb_rational_arithmetic_unit.sv @@
module tb_rational_arithmetic_unit;
    import rau_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        cmd_t              command;
        logic signed [15:0] left_num;
        logic signed [15:0] left_den;
        logic signed [15:0] right_num;
        logic signed [15:0] right_den;
    } operand_set_t;

    typedef struct packed {
        logic signed [NUM_OUT_W-1:0] result_num;
        logic signed [DEN_OUT_W-1:0] result_den;
        logic                        undefined;
        logic                        operands_equal;
    } reduced_t;

    logic clk;
    logic rst_n;

    rau_in_if  operands ();
    rau_out_if result ();

    rational_arithmetic_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (operands.sink),
        .result   (result.source)
    );

    operand_set_t pending_q[$];
    reduced_t     reduced_q[$];
    int           mismatches;
    bit           burst_mode;
    int           hold_off;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
        longint unsigned t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic reduced_t reduce_fraction(operand_set_t s);
        reduced_t        r;
        longint          ln;
        longint          ld;
        longint          rn;
        longint          rd;
        longint          n;
        longint          d;
        longint unsigned g;
        ln = s.left_num;
        ld = s.left_den;
        rn = s.right_num;
        rd = s.right_den;
        case (s.command)
            CMD_ADD: begin n = ln * rd + ld * rn; d = ld * rd; end
            CMD_SUB: begin n = ln * rd - ld * rn; d = ld * rd; end
            CMD_MUL: begin n = ln * rn; d = ld * rd; end
            default: begin n = ln * rd; d = ld * rn; end
        endcase
        g = gcd_of((n < 0) ? -n : n, (d < 0) ? -d : d);
        r.operands_equal = (ln == rn) && (ld == rd);
        if (g == 0)
        begin
            r.result_num = '0;
            r.result_den = '0;
            r.undefined  = 1'b1;
        end
        else
        begin
            r.result_num = n / longint'(g);
            r.result_den = d / longint'(g);
            r.undefined  = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    function automatic logic signed [15:0] pick_field();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(int'($urandom_range(0, 4)) - 2);
            3: return 16'(int'($urandom_range(0, 40)) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operands.valid     <= 1'b0;
            operands.command   <= CMD_ADD;
            operands.left_num  <= '0;
            operands.left_den  <= '0;
            operands.right_num <= '0;
            operands.right_den <= '0;
        end
        else
        begin
            if (operands.valid && operands.ready)
            begin
                reduced_q.push_back(reduce_fraction(pending_q.pop_front()));
            end
            if ((operands.valid && !operands.ready) ||
                (pending_q.size() != 0 && (burst_mode || $urandom_range(0, 99) >= 24)))
            begin
                operands.valid     <= 1'b1;
                operands.command   <= pending_q[0].command;
                operands.left_num  <= pending_q[0].left_num;
                operands.left_den  <= pending_q[0].left_den;
                operands.right_num <= pending_q[0].right_num;
                operands.right_den <= pending_q[0].right_den;
            end
            else
            begin
                operands.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off <= HOLD_CYCLES;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (reduced_q.size() == 0)
                begin
                    $display("%0t unexpected result transaction", $time);
                    mismatches++;
                end
                else
                begin
                    reduced_t want;
                    want = reduced_q.pop_front();
                    if (result.result_num !== want.result_num)
                        report_mismatch("result_num", result.result_num, want.result_num);
                    if (result.result_den !== want.result_den)
                        report_mismatch("result_den", result.result_den, want.result_den);
                    if (result.undefined !== want.undefined)
                        report_mismatch("undefined", result.undefined, want.undefined);
                    if (result.operands_equal !== want.operands_equal)
                        report_mismatch("operands_equal", result.operands_equal,
                                        want.operands_equal);
                end
            end
            if (hold_off > 0)
            begin
                result.ready <= 1'b0;
            end
            else
            begin
                result.ready <= burst_mode || $urandom_range(0, 99) >= 24;
            end
        end
    end

    initial
    begin
        operand_set_t s;
        cmd_t         c;
        mismatches    = 0;
        burst_mode    = 1'b0;
        rst_n         = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < 4; k++)
        begin
            c = cmd_t'(k);
            pending_q.push_back({c, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
            pending_q.push_back({c, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff});
            pending_q.push_back({c, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000});
            pending_q.push_back({c, 16'sh0000, 16'sh0003, 16'sh0005, 16'shfff9});
            pending_q.push_back({c, 16'sh0004, 16'sh0000, 16'shfffa, 16'sh0000});
            pending_q.push_back({c, 16'shffff, 16'shffff, 16'sh0002, 16'sh0004});
        end

        for (int i = 0; i < 950; i++)
        begin
            s.command   = cmd_t'($urandom_range(0, 3));
            s.left_num  = pick_field();
            s.left_den  = pick_field();
            if ($urandom_range(0, 9) == 0)
            begin
                s.right_num = s.left_num;
                s.right_den = s.left_den;
            end
            else
            begin
                s.right_num = pick_field();
                s.right_den = pick_field();
            end
            pending_q.push_back(s);
        end

        wait (pending_q.size() < 700);
        burst_mode = 1'b1;
        wait (pending_q.size() < 450);
        burst_mode = 1'b0;
        wait (pending_q.size() == 0);
        wait (reduced_q.size() == 0);
        repeat (300) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/rau_pkg.sv
rtl/rau_in_if.sv
rtl/rau_out_if.sv
rtl/rau_front.sv
rtl/rau_gcd_step.sv
rtl/rau_div_step.sv
rtl/rational_arithmetic_unit.sv
dv/tb_rational_arithmetic_unit.sv
